// ===== hdl/tatr_pkg.sv =====
// shared constants and the schedule function for the scheduled torus router
// no dependencies
`timescale 1ns / 1ps

package tatr_pkg;

	localparam int GRID_WIDTH_DEF   = 4;
	localparam int PAYLOAD_BITS_DEF = 64;
	localparam int QUEUE_DEPTH_DEF  = 3;

	localparam logic [1:0] PORT_EAST  = 2'd0;
	localparam logic [1:0] PORT_NORTH = 2'd1;
	localparam logic [1:0] PORT_LOCAL = 2'd2;
	localparam logic [1:0] PORT_NONE  = 2'd3;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_INJECT = 1'b1;

	// schedule offset of a step within the grid (values fit in 5 bits)
	function automatic logic [4:0] node_offset(input logic [4:0] c, input logic [4:0] n);
		logic [4:0] r;
		begin
			if (n[0] && c == n - 5'd2)
				r = n >> 1;
			else if (!c[0] && !n[0])
				r = (n >> 1) + (c >> 1);
			else if (!c[0])
				r = (n >> 1) + (c >> 1) + 5'd1;
			else
				r = (n >> 1) - (c >> 1) - 5'd1;
			return r;
		end
	endfunction

endpackage

// ===== hdl/tatr_front.sv =====
// front: FIFO of incoming request words, staging requests into the work queue
// depends on tatr_pkg
`timescale 1ns / 1ps

module tatr_front #(
	parameter int PAYLOAD_BITS = tatr_pkg::PAYLOAD_BITS_DEF,
	parameter int FQ_DEPTH     = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [1+2*(17+PAYLOAD_BITS)+8+PAYLOAD_BITS-1:0] in_word,
	output logic                    q_valid,
	input  logic                    q_take,
	output logic [1+2*(17+PAYLOAD_BITS)+8+PAYLOAD_BITS-1:0] q_word
);
	localparam int W  = 1 + 2*(17+PAYLOAD_BITS) + 8 + PAYLOAD_BITS;
	localparam int AW = $clog2(FQ_DEPTH);

	logic [W-1:0]  mem_q [FQ_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full    = (cnt_q == (AW+1)'(FQ_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_word  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wp_q] <= in_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wp_q <= (wp_q == AW'(FQ_DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (q_take && q_valid)
				rp_q <= (rp_q == AW'(FQ_DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(q_take && q_valid);
		end
	end
endmodule

// ===== hdl/tatr_back.sv =====
// back: router state, schedules and result sequencing for one request at a time
// depends on tatr_pkg
`timescale 1ns / 1ps

module tatr_back #(
	parameter int GRID_WIDTH   = tatr_pkg::GRID_WIDTH_DEF,
	parameter int PAYLOAD_BITS = tatr_pkg::PAYLOAD_BITS_DEF,
	parameter int QUEUE_DEPTH  = tatr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              rank,
	input  logic                    q_valid,
	output logic                    q_take,
	input  logic [1+2*(17+PAYLOAD_BITS)+8+PAYLOAD_BITS-1:0] q_word,
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              port,
	output logic [7:0]              flit_dest,
	output logic [7:0]              flit_src,
	output logic [PAYLOAD_BITS-1:0] flit_payload,
	output logic                    inject_accepted,
	output logic                    last
);
	localparam int N   = GRID_WIDTH;
	localparam int SW  = $clog2(N);
	localparam int QW  = $clog2(QUEUE_DEPTH+1);
	localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int ROUND_LEN = N*N*(N-1)/2;
	localparam int RW  = $clog2(ROUND_LEN+2);
	localparam logic [4:0] N5 = 5'(N);

	typedef logic [PAYLOAD_BITS-1:0] pay_t;
	typedef struct packed {
		logic [1:0] port;
		logic [7:0] d;
		logic [7:0] s;
		pay_t       p;
		logic       acc;
		logic       lst;
	} res_t;

	// request fields
	logic       cmd, wv, sv;
	logic [7:0] wd, ws, sd, ss, id;
	pay_t       wp, sp, ip;
	assign {cmd, wv, wd, ws, wp, sv, sd, ss, sp, id, ip} = q_word;

	// state
	logic [7:0]     iqd_q [QUEUE_DEPTH];
	pay_t           iqp_q [QUEUE_DEPTH];
	logic [QW-1:0]  iqc_q;
	logic           hv_q;
	logic [7:0]     hd_q;
	pay_t           hp_q;
	logic [N-1:0]   cv_q;
	logic [7:0]     cd_q [N];
	logic [7:0]     cs_q [N];
	pay_t           cp_q [N];
	logic [3:0]     hph_q, hst_q, hwt_q, vst_q, vwt_q;
	logic [RW-1:0]  rt_q;

	// result buffer: up to four results per request
	res_t       ob_q [4];
	logic [2:0] ocnt_q, orp_q;

	// phase zero drain state, one move per cycle
	localparam logic [1:0] ST_IDLE = 2'd0, ST_DRAIN = 2'd1;
	logic [1:0]    st_q;
	logic [SW:0]   dcnt_q;

	// slot of a destination relative to this rank
	function automatic logic [SW-1:0] slot_of(input logic [7:0] d, input logic [7:0] r);
		logic [8:0] s;
		begin
			if (d <= r)
				s = 9'((r - d) / N);
			else
				s = 9'(N) - 9'((d - r) / N);
			return SW'(s % N);
		end
	endfunction

	function automatic logic [31:0] shift_rows(input logic [31:0] t, input logic [7:0] r,
			input logic [4:0] rows);
		begin
			if (32'(r / N) >= 32'(rows))
				return t - 32'(rows) * N;
			return t + N*N - 32'(rows) * N;
		end
	endfunction

	logic busy;
	assign busy  = (ocnt_q != '0) || (st_q != ST_IDLE);
	assign empty = (ocnt_q == '0);
	assign {port, flit_dest, flit_src, flit_payload, inject_accepted, last} = ob_q[orp_q[1:0]];

	// refill candidate
	logic          rf;
	assign rf = !hv_q && (iqc_q != '0);

	// drain step condition using the head after refill
	logic          dh_v;
	logic [7:0]    dh_d;
	pay_t          dh_p;
	logic [SW-1:0] dslot;
	logic          dmove;
	always_comb begin
		dh_v = hv_q || rf;
		dh_d = hv_q ? hd_q : iqd_q[0];
		dh_p = hv_q ? hp_q : iqp_q[0];
		dslot = slot_of(dh_d, rank);
		dmove = dh_v && ((dh_d % N) == (rank % N)) && !cv_q[dslot];
	end

	// tick network cycle, computed on the state with refilled head
	logic [4:0]  col, nod, vofs;
	logic [31:0] ht, wt;
	logic [3:0]  hph_e, hst_e, vst_e;
	logic        wrap;
	res_t        r_e, r_n, r_sl, r_wl;
	logic        e_v, n_v, nbusy, sl, wl, cw;
	logic [SW-1:0] cws, vslot;
	logic        vtake, htake;
	logic [3:0]  hph_n, hst_n, hwt_n, vst_n, vwt_n;
	always_comb begin
		wrap  = (rt_q == RW'(ROUND_LEN));
		hph_e = wrap ? 4'd0 : hph_q;
		hst_e = wrap ? 4'd0 : hst_q;
		vst_e = wrap ? 4'd0 : vst_q;
		if (hph_e == 4'd0) hph_e = 4'd1;
		col = 5'd0; nod = 5'd0; ht = '0; vofs = '0;
		e_v = 1'b0; n_v = 1'b0; nbusy = 1'b0; sl = 1'b0; wl = 1'b0; cw = 1'b0;
		cws = '0; vslot = '0; vtake = 1'b0; htake = 1'b0;
		r_e  = '{tatr_pkg::PORT_EAST, 8'd0, 8'd0, '0, 1'b0, 1'b0};
		r_n  = '{tatr_pkg::PORT_NORTH, 8'd0, 8'd0, '0, 1'b0, 1'b0};
		r_sl = '{tatr_pkg::PORT_LOCAL, sd, ss, sp, 1'b0, 1'b0};
		r_wl = '{tatr_pkg::PORT_LOCAL, wd, ws, wp, 1'b0, 1'b0};
		hph_n = hph_e; hst_n = hst_e; hwt_n = hwt_q - 4'd1;
		vst_n = vst_e; vwt_n = vwt_q - 4'd1;
		if (hwt_q == 4'd0) begin
			if (5'(hph_e) == N5 - 5'd1)
				col = N5 - 5'd1;
			else if (N5[0] && 5'(hph_e) == N5 - 5'd2)
				col = N5 >> 1;
			else if (hph_e[0] && !N5[0])
				col = (N5 >> 1) + 5'(hph_e >> 1);
			else if (hph_e[0])
				col = (N5 >> 1) + 5'd1;
			else
				col = (N5 >> 1) - 5'(hph_e >> 1);
			nod = (5'(hst_e) == N5 - 5'd1) ? 5'd0 : tatr_pkg::node_offset(5'(hst_e), N5);
			ht = (32'((32'(rank) + 32'(col)) / N) == 32'(rank / N)) ?
				32'(rank) + 32'(col) : 32'(rank) + 32'(col) - N;
			ht = shift_rows(ht, rank, nod);
			if (dh_v && 32'(dh_d) == ht) begin
				e_v = 1'b1; htake = 1'b1;
				r_e.d = dh_d; r_e.s = rank; r_e.p = dh_p;
			end
			hwt_n = 4'(col - 5'd1);
			if (5'(hst_e) == N5 - 5'd1) begin
				hph_n = hph_e + 4'd1; hst_n = 4'd0;
			end else
				hst_n = hst_e + 4'd1;
		end
		if (vwt_q == 4'd0) begin
			vofs = tatr_pkg::node_offset(5'(vst_e), N5);
			vslot = SW'(vofs);
			if (vofs < N5 && cv_q[vslot]) begin
				n_v = 1'b1; nbusy = 1'b1; vtake = 1'b1;
				r_n.d = cd_q[vslot]; r_n.s = cs_q[vslot]; r_n.p = cp_q[vslot];
			end
			vwt_n = 4'(vofs - 5'd1);
			vst_n = (5'(vst_e) == N5 - 5'd2) ? 4'd0 : vst_e + 4'd1;
		end
		if (sv) begin
			if (sd == rank) sl = 1'b1;
			else begin
				n_v = 1'b1; nbusy = 1'b1; r_n.d = sd; r_n.s = ss; r_n.p = sp;
			end
		end
		if (wv) begin
			wt = (vofs != 5'd0) ? shift_rows(32'(rank), rank, vofs) : 32'(N*N);
			if (wd == rank) wl = 1'b1;
			else if (32'(wd) == wt && !nbusy) begin
				n_v = 1'b1; r_n.d = wd; r_n.s = ws; r_n.p = wp;
			end else if ((wd % N) == (rank % N)) begin
				cw = 1'b1; cws = slot_of(wd, rank);
			end else begin
				e_v = 1'b1; r_e.d = wd; r_e.s = ws; r_e.p = wp;
			end
		end else
			wt = '0;
	end

	logic go;
	logic need_drain;
	assign need_drain = (cmd == tatr_pkg::CMD_TICK) && (wrap || hph_q == 4'd0);
	assign go = q_valid && !busy;
	assign q_take = (st_q == ST_DRAIN) ? 1'b0 : go && !need_drain;

	always_ff @(posedge clk) begin
		res_t       rl [4];
		logic [2:0] k;
		// payload updates
		if (go && cmd == tatr_pkg::CMD_INJECT) begin
			if (rf) begin
				for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
					iqd_q[i] <= iqd_q[i+1];
					iqp_q[i] <= iqp_q[i+1];
				end
				hd_q <= iqd_q[0]; hp_q <= iqp_q[0];
				if (iqc_q - QW'(1) < QW'(QUEUE_DEPTH)) begin
					iqd_q[QIW'(iqc_q - QW'(1))] <= id;
					iqp_q[QIW'(iqc_q - QW'(1))] <= ip;
				end
			end else if (iqc_q < QW'(QUEUE_DEPTH)) begin
				iqd_q[QIW'(iqc_q)] <= id;
				iqp_q[QIW'(iqc_q)] <= ip;
			end
			ob_q[0] <= '{tatr_pkg::PORT_NONE, id, rank, ip,
				rf || (iqc_q < QW'(QUEUE_DEPTH)), 1'b1};
		end else if (st_q == ST_DRAIN || (go && need_drain)) begin
			if (rf) begin
				for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
					iqd_q[i] <= iqd_q[i+1];
					iqp_q[i] <= iqp_q[i+1];
				end
				hd_q <= iqd_q[0]; hp_q <= iqp_q[0];
			end
			if (st_q == ST_DRAIN && dmove) begin
				cd_q[dslot] <= dh_d; cs_q[dslot] <= rank; cp_q[dslot] <= dh_p;
			end
		end else if (go) begin
			if (rf) begin
				for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
					iqd_q[i] <= iqd_q[i+1];
					iqp_q[i] <= iqp_q[i+1];
				end
				hd_q <= iqd_q[0]; hp_q <= iqp_q[0];
			end
			if (cw) begin
				cd_q[cws] <= wd; cs_q[cws] <= ws; cp_q[cws] <= wp;
			end
			for (int i = 0; i < 4; i++) rl[i] = r_e;
			k = 3'd0;
			if (e_v) begin rl[k[1:0]] = r_e; k = k + 3'd1; end
			if (n_v) begin rl[k[1:0]] = r_n; k = k + 3'd1; end
			if (sl) begin rl[k[1:0]] = r_sl; k = k + 3'd1; end
			if (wl) begin rl[k[1:0]] = r_wl; k = k + 3'd1; end
			if (k == 3'd0) begin
				rl[0] = '{tatr_pkg::PORT_NONE, 8'd0, 8'd0, '0, 1'b0, 1'b0}; k = 3'd1;
			end
			rl[2'(k - 3'd1)].lst = 1'b1;
			for (int i = 0; i < 4; i++) ob_q[i] <= rl[i];
		end
	end

	logic [2:0] nres;
	always_comb begin
		nres = 3'(e_v) + 3'(n_v) + 3'(sl) + 3'(wl);
		if (nres == 3'd0) nres = 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iqc_q <= '0; hv_q <= 1'b0; cv_q <= '0;
			hph_q <= '0; hst_q <= '0; hwt_q <= '0; vst_q <= '0; vwt_q <= '0;
			rt_q <= '0; ocnt_q <= '0; orp_q <= '0; st_q <= ST_IDLE; dcnt_q <= '0;
		end else begin
			if (pop && !empty) begin
				ocnt_q <= ocnt_q - 3'd1;
				orp_q  <= orp_q + 3'd1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (go && cmd == tatr_pkg::CMD_INJECT) begin
						if (rf) hv_q <= 1'b1;
						else if (iqc_q < QW'(QUEUE_DEPTH)) iqc_q <= iqc_q + QW'(1);
						ocnt_q <= 3'd1; orp_q <= '0;
					end else if (go && need_drain) begin
						if (rf) begin hv_q <= 1'b1; iqc_q <= iqc_q - QW'(1); end
						if (wrap) begin
							rt_q <= '0; hst_q <= '0; vst_q <= '0;
						end
						hph_q <= 4'd0;
						dcnt_q <= '0;
						st_q <= ST_DRAIN;
					end else if (go) begin
						if (rf) iqc_q <= iqc_q - QW'(1);
						hv_q <= dh_v && !htake;
						hph_q <= hph_n; hst_q <= hst_n; hwt_q <= hwt_n;
						vst_q <= vst_n; vwt_q <= vwt_n;
						rt_q <= rt_q + RW'(1);
						if (vtake) cv_q[vslot] <= 1'b0;
						if (cw) cv_q[cws] <= 1'b1;
						ocnt_q <= nres; orp_q <= '0;
					end
				end
				ST_DRAIN: begin
					// head already refilled here; one move per cycle
					if (rf) begin hv_q <= 1'b1; iqc_q <= iqc_q - QW'(1); end
					if (dcnt_q < (SW+1)'(N-1) && dmove) begin
						cv_q[dslot] <= 1'b1;
						hv_q <= 1'b0;
						if (rf) iqc_q <= iqc_q - QW'(1);
						dcnt_q <= dcnt_q + (SW+1)'(1);
					end else begin
						hph_q <= 4'd1;
						st_q  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/torus_all_to_all_scheduled_router_top.sv =====
// one request in flight: injects are answered directly, ticks at phase zero first run a
// corner drain; results leave through a 4-entry buffer
// next request enters once all results of the current one are popped
// reset is asynchronous active low: queues empty, head and corner slots invalid,
// schedule counters and node_rank zero
`timescale 1ns / 1ps

module torus_all_to_all_scheduled_router_top #(
	parameter int GRID_WIDTH   = tatr_pkg::GRID_WIDTH_DEF,
	parameter int PAYLOAD_BITS = tatr_pkg::PAYLOAD_BITS_DEF,
	parameter int QUEUE_DEPTH  = tatr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [7:0]              cfg_data,
	input  logic                    push,
	output logic                    full,
	input  logic                    command,
	input  logic                    west_valid,
	input  logic [7:0]              west_dest,
	input  logic [7:0]              west_src,
	input  logic [PAYLOAD_BITS-1:0] west_payload,
	input  logic                    south_valid,
	input  logic [7:0]              south_dest,
	input  logic [7:0]              south_src,
	input  logic [PAYLOAD_BITS-1:0] south_payload,
	input  logic [7:0]              inject_dest,
	input  logic [PAYLOAD_BITS-1:0] inject_payload,
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              port,
	output logic [7:0]              flit_dest,
	output logic [7:0]              flit_src,
	output logic [PAYLOAD_BITS-1:0] flit_payload,
	output logic                    inject_accepted,
	output logic                    last
);
	localparam int W = 1 + 2*(17+PAYLOAD_BITS) + 8 + PAYLOAD_BITS;

	logic [7:0]   rank_q;
	logic [W-1:0] in_word, q_word;
	logic         q_valid, q_take;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rank_q <= '0;
		else if (cfg_valid)
			rank_q <= cfg_data;
	end

	assign in_word = {command, west_valid, west_dest, west_src, west_payload,
		south_valid, south_dest, south_src, south_payload, inject_dest, inject_payload};

	tatr_front #(.PAYLOAD_BITS(PAYLOAD_BITS), .FQ_DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.q_valid(q_valid), .q_take(q_take), .q_word(q_word)
	);

	tatr_back #(.GRID_WIDTH(GRID_WIDTH), .PAYLOAD_BITS(PAYLOAD_BITS),
		.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .rank(rank_q), .q_valid(q_valid), .q_take(q_take),
		.q_word(q_word), .empty(empty), .pop(pop), .port(port), .flit_dest(flit_dest),
		.flit_src(flit_src), .flit_payload(flit_payload),
		.inject_accepted(inject_accepted), .last(last)
	);
endmodule
